/* src/lod_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lock-order deadlock detector package
// Shared constants, result codes and the controller state type.
// ----------------------------------------------------------------------------
package lod_pkg;

   // Default sizes of the graph, the thread set and the held-lock stacks.
   localparam int LOCKS_DEF       = 32;
   localparam int THREADS_DEF     = 4;
   localparam int STACK_DEPTH_DEF = 16;

   // Fixed field widths of the request and response words.
   localparam int THREAD_W = 2;
   localparam int LOCK_W   = 5;
   localparam int STATUS_W = 3;

   // Opcodes.
   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STAT_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_DEADLOCK     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_REL_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_REL_MISMATCH = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_OVERFLOW     = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_HALTED       = 3'd5;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_TOP,
      S_EDGE,
      S_ROOT,
      S_SCAN,
      S_POP,
      S_FIN
   } state_type;

endpackage

/* src/lod_matrix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lock-order matrix
// One row per lock; bit b of row a marks an order edge from lock a to lock b.
// Rows carry valid bits so that reset empties the graph at once.
// ----------------------------------------------------------------------------
module lod_matrix #(
   parameter int LOCKS = lod_pkg::LOCKS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [$clog2(LOCKS)-1:0]   rd_addr,
   output logic [LOCKS-1:0]           rd_row,
   input  logic                       wr_en,
   input  logic [$clog2(LOCKS)-1:0]   wr_addr,
   input  logic [LOCKS-1:0]           wr_row
);

   logic [LOCKS-1:0] mem [LOCKS];
   logic [LOCKS-1:0] vld_ff;
   logic [LOCKS-1:0] rd_row_ff;

   // Row storage and registered read; a row never written reads as empty.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_row_ff <= vld_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   // Row valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_row = rd_row_ff;

endmodule

/* src/lod_hstack.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Held-lock stacks
// One stack of lock ids per thread in a shared memory, with a fill count
// per thread in flip-flops. The top entry is read through a register.
// ----------------------------------------------------------------------------
module lod_hstack #(
   parameter int THREADS     = lod_pkg::THREADS_DEF,
   parameter int STACK_DEPTH = lod_pkg::STACK_DEPTH_DEF,
   localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1,
   localparam int CW = $clog2(STACK_DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [TW-1:0]               thread,
   input  logic                        rd_en,
   input  logic                        push_en,
   input  logic                        pop_en,
   input  logic [lod_pkg::LOCK_W-1:0]  push_lock,
   output logic [CW-1:0]               count,
   output logic [lod_pkg::LOCK_W-1:0]  top_lock
);

   localparam int ENTRIES = THREADS * STACK_DEPTH;
   localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [lod_pkg::LOCK_W-1:0] mem [ENTRIES];
   logic [lod_pkg::LOCK_W-1:0] top_ff;
   logic [CW-1:0]              count_ff [THREADS];
   logic [AW-1:0]              rd_addr;
   logic [AW-1:0]              wr_addr;

   assign count = count_ff[thread];

   // The top sits one below the fill count; a push lands at the fill count.
   assign rd_addr = AW'(int'(thread) * STACK_DEPTH + int'(count) - 1);
   assign wr_addr = AW'(int'(thread) * STACK_DEPTH + int'(count));

   // Stack memory.
   always_ff @(posedge clock) begin
      if (push_en) begin
         mem[wr_addr] <= push_lock;
      end
      if (rd_en) begin
         top_ff <= mem[rd_addr];
      end
   end

   // Fill counts.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < THREADS; i++) begin
            count_ff[i] <= '0;
         end
      end else if (push_en) begin
         count_ff[thread] <= count + CW'(1);
      end else if (pop_en) begin
         count_ff[thread] <= count - CW'(1);
      end
   end

   assign top_lock = top_ff;

endmodule

/* src/lod_sstack.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Search stack
// Holds the ancestors of the node under scan during the depth-first search:
// each entry keeps a node and the next neighbor to try on return.
// ----------------------------------------------------------------------------
module lod_sstack #(
   parameter int LOCKS = lod_pkg::LOCKS_DEF,
   localparam int LW = $clog2(LOCKS),
   localparam int NW = $clog2(LOCKS + 1)
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [LW-1:0]   wr_addr,
   input  logic [LW-1:0]   wr_node,
   input  logic [NW-1:0]   wr_next,
   input  logic            rd_en,
   input  logic [LW-1:0]   rd_addr,
   output logic [LW-1:0]   rd_node,
   output logic [NW-1:0]   rd_next
);

   logic [LW+NW-1:0] mem [LOCKS];
   logic [LW+NW-1:0] rd_ff;

   // Frame storage with a registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_node, wr_next};
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_node = rd_ff[LW+NW-1:NW];
   assign rd_next = rd_ff[NW-1:0];

endmodule

/* src/lock_order_deadlock_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lock-order deadlock detector
// Tracks held locks per thread, records lock-order edges and runs a
// depth-first search for a cycle whenever a new edge appears.
//
//   Channel | Direction | Ports
//   --------+-----------+--------------------------------------------------
//   req     | in        | req_valid, req_stall, opcode, thread_id, lock_id
//   rsp     | out       | rsp_valid, rsp_stall, status, new_edge, cycle_*
//
// An event that needs no stack read goes straight to its response; a
// release or an acquire over a held lock first reads the stack top. A
// new order edge starts the search, which steps through each root, each
// graph edge scanned and each return from a node, all bound by the
// single read port of the order matrix. One word is handled at a time.
// Reset is synchronous and empties the graph, the stacks and the halt flag.
// A stalled response waits in its output register while the next word is
// taken in; that word finishes once the register is free.
// ----------------------------------------------------------------------------
module lock_order_deadlock_detector #(
   parameter int LOCKS       = lod_pkg::LOCKS_DEF,
   parameter int THREADS     = lod_pkg::THREADS_DEF,
   parameter int STACK_DEPTH = lod_pkg::STACK_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [lod_pkg::THREAD_W-1:0]  req_thread_id,
   input  logic [lod_pkg::LOCK_W-1:0]    req_lock_id,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lod_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_new_edge,
   output logic [lod_pkg::LOCK_W-1:0]    rsp_cycle_from,
   output logic [lod_pkg::LOCK_W-1:0]    rsp_cycle_to
);

   localparam int LW = $clog2(LOCKS);
   localparam int NW = $clog2(LOCKS + 1);
   localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   lod_pkg::state_type state_ff, state_in;

   logic                          op_ff, op_in;
   logic [TW-1:0]                 thr_ff, thr_in;
   logic [lod_pkg::LOCK_W-1:0]    lock_ff, lock_in;
   logic [LW-1:0]                 top_ff, top_in;
   logic                          halted_ff, halted_in;
   logic [LOCKS-1:0]              seen_ff, seen_in;
   logic [LOCKS-1:0]              done_ff, done_in;
   logic [LW-1:0]                 cur_v_ff, cur_v_in;
   logic [NW-1:0]                 cur_n_ff, cur_n_in;
   logic [LW-1:0]                 sp_ff, sp_in;
   logic [lod_pkg::STATUS_W-1:0]  res_status_ff, res_status_in;
   logic                          res_edge_ff, res_edge_in;
   logic [LW-1:0]                 res_from_ff, res_from_in;
   logic [LW-1:0]                 res_to_ff, res_to_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lod_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic                          rsp_edge_ff;
   logic [lod_pkg::LOCK_W-1:0]    rsp_from_ff;
   logic [lod_pkg::LOCK_W-1:0]    rsp_to_ff;

   // Memory port signals.
   logic [TW-1:0]               hs_thread;
   logic                        hs_rd, hs_push, hs_pop;
   logic [lod_pkg::LOCK_W-1:0]  hs_push_lock;
   logic [CW-1:0]               hs_count;
   logic [lod_pkg::LOCK_W-1:0]  hs_top;
   logic                        mx_rd, mx_wr;
   logic [LW-1:0]               mx_rd_addr;
   logic [LOCKS-1:0]            mx_row;
   logic [LOCKS-1:0]            mx_wr_row;
   logic                        ss_wr, ss_rd;
   logic [LW-1:0]               ss_rd_addr;
   logic [LW-1:0]               ss_node;
   logic [NW-1:0]               ss_next;

   // Search helpers.
   logic           scan_hit;
   logic [LW-1:0]  scan_idx;
   logic           root_hit;
   logic [LW-1:0]  root_idx;
   logic           accept;
   logic           in_range;
   logic           load_rsp;
   logic [LW-1:0]  lock_node;

   lod_hstack #(
      .THREADS     (THREADS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_hstack (
      .clock     (clock),
      .reset     (reset),
      .thread    (hs_thread),
      .rd_en     (hs_rd),
      .push_en   (hs_push),
      .pop_en    (hs_pop),
      .push_lock (hs_push_lock),
      .count     (hs_count),
      .top_lock  (hs_top)
   );

   lod_matrix #(
      .LOCKS (LOCKS)
   ) u_matrix (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mx_rd),
      .rd_addr (mx_rd_addr),
      .rd_row  (mx_row),
      .wr_en   (mx_wr),
      .wr_addr (top_ff),
      .wr_row  (mx_wr_row)
   );

   lod_sstack #(
      .LOCKS (LOCKS)
   ) u_sstack (
      .clock   (clock),
      .wr_en   (ss_wr),
      .wr_addr (sp_ff),
      .wr_node (cur_v_ff),
      .wr_next (NW'(scan_idx) + NW'(1)),
      .rd_en   (ss_rd),
      .rd_addr (ss_rd_addr),
      .rd_node (ss_node),
      .rd_next (ss_next)
   );

   assign accept    = req_valid && (state_ff == lod_pkg::S_IDLE);
   assign req_stall = (state_ff != lod_pkg::S_IDLE);
   assign in_range  = (int'(req_thread_id) < THREADS) && (int'(req_lock_id) < LOCKS);
   assign hs_thread = (state_ff == lod_pkg::S_IDLE) ? TW'(req_thread_id) : thr_ff;
   assign lock_node = LW'(lock_ff);
   assign load_rsp  = (state_ff == lod_pkg::S_FIN) && (!rsp_valid_ff || !rsp_stall);
   assign ss_rd_addr = sp_ff - LW'(1);
   assign mx_wr_row  = mx_row | (LOCKS'(1) << lock_node);

   // Lowest neighbor at or above the scan position in the current row.
   always_comb begin
      scan_hit = 1'b0;
      scan_idx = '0;
      for (int i = LOCKS - 1; i >= 0; i--) begin
         if (mx_row[i] && (i >= int'(cur_n_ff))) begin
            scan_hit = 1'b1;
            scan_idx = LW'(i);
         end
      end
   end

   // Lowest lock not yet reached, the next search root.
   always_comb begin
      root_hit = 1'b0;
      root_idx = '0;
      for (int i = LOCKS - 1; i >= 0; i--) begin
         if (!seen_ff[i]) begin
            root_hit = 1'b1;
            root_idx = LW'(i);
         end
      end
   end

   // Controller: next state, memory commands and result bookkeeping.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      thr_in        = thr_ff;
      lock_in       = lock_ff;
      top_in        = top_ff;
      halted_in     = halted_ff;
      seen_in       = seen_ff;
      done_in       = done_ff;
      cur_v_in      = cur_v_ff;
      cur_n_in      = cur_n_ff;
      sp_in         = sp_ff;
      res_status_in = res_status_ff;
      res_edge_in   = res_edge_ff;
      res_from_in   = res_from_ff;
      res_to_in     = res_to_ff;
      hs_rd         = 1'b0;
      hs_push       = 1'b0;
      hs_pop        = 1'b0;
      hs_push_lock  = lock_ff;
      mx_rd         = 1'b0;
      mx_rd_addr    = cur_v_ff;
      mx_wr         = 1'b0;
      ss_wr         = 1'b0;
      ss_rd         = 1'b0;

      case (state_ff)
         lod_pkg::S_IDLE: begin
            if (accept) begin
               op_in         = req_opcode;
               thr_in        = TW'(req_thread_id);
               lock_in       = req_lock_id;
               hs_push_lock  = req_lock_id;
               res_status_in = lod_pkg::STAT_OK;
               res_edge_in   = 1'b0;
               res_from_in   = '0;
               res_to_in     = '0;
               state_in      = lod_pkg::S_FIN;
               if (halted_ff) begin
                  res_status_in = lod_pkg::STAT_HALTED;
               end else if (in_range) begin
                  if (req_opcode == lod_pkg::OP_ACQUIRE) begin
                     if (hs_count >= CW'(STACK_DEPTH)) begin
                        res_status_in = lod_pkg::STAT_OVERFLOW;
                     end else if (hs_count == '0) begin
                        hs_push = 1'b1;
                     end else begin
                        hs_rd    = 1'b1;
                        state_in = lod_pkg::S_TOP;
                     end
                  end else begin
                     if (hs_count == '0) begin
                        res_status_in = lod_pkg::STAT_REL_EMPTY;
                        halted_in     = 1'b1;
                     end else begin
                        hs_rd    = 1'b1;
                        state_in = lod_pkg::S_TOP;
                     end
                  end
               end
            end
         end

         // Top of the thread's stack is on hand.
         lod_pkg::S_TOP: begin
            top_in = LW'(hs_top);
            if (op_ff == lod_pkg::OP_ACQUIRE) begin
               if (hs_top == lock_ff) begin
                  hs_push  = 1'b1;
                  state_in = lod_pkg::S_FIN;
               end else begin
                  mx_rd      = 1'b1;
                  mx_rd_addr = LW'(hs_top);
                  state_in   = lod_pkg::S_EDGE;
               end
            end else begin
               if (hs_top != lock_ff) begin
                  res_status_in = lod_pkg::STAT_REL_MISMATCH;
                  halted_in     = 1'b1;
               end else begin
                  hs_pop = 1'b1;
               end
               state_in = lod_pkg::S_FIN;
            end
         end

         // Row of the top lock is on hand; add the edge if it is new.
         lod_pkg::S_EDGE: begin
            if (mx_row[lock_node]) begin
               hs_push  = 1'b1;
               state_in = lod_pkg::S_FIN;
            end else begin
               mx_wr       = 1'b1;
               res_edge_in = 1'b1;
               seen_in     = '0;
               done_in     = '0;
               state_in    = lod_pkg::S_ROOT;
            end
         end

         // Start a new tree at the lowest unreached lock, or finish clean.
         lod_pkg::S_ROOT: begin
            if (!root_hit) begin
               hs_push  = 1'b1;
               state_in = lod_pkg::S_FIN;
            end else begin
               seen_in[root_idx] = 1'b1;
               cur_v_in   = root_idx;
               cur_n_in   = '0;
               sp_in      = '0;
               mx_rd      = 1'b1;
               mx_rd_addr = root_idx;
               state_in   = lod_pkg::S_SCAN;
            end
         end

         // Scan the current node's row for its next neighbor.
         lod_pkg::S_SCAN: begin
            if (!scan_hit) begin
               done_in[cur_v_ff] = 1'b1;
               if (sp_ff == '0) begin
                  state_in = lod_pkg::S_ROOT;
               end else begin
                  ss_rd    = 1'b1;
                  sp_in    = sp_ff - LW'(1);
                  state_in = lod_pkg::S_POP;
               end
            end else if (!seen_ff[scan_idx]) begin
               seen_in[scan_idx] = 1'b1;
               ss_wr      = 1'b1;
               sp_in      = sp_ff + LW'(1);
               cur_v_in   = scan_idx;
               cur_n_in   = '0;
               mx_rd      = 1'b1;
               mx_rd_addr = scan_idx;
            end else if (!done_ff[scan_idx]) begin
               res_status_in = lod_pkg::STAT_DEADLOCK;
               res_from_in   = cur_v_ff;
               res_to_in     = scan_idx;
               halted_in     = 1'b1;
               state_in      = lod_pkg::S_FIN;
            end else begin
               cur_n_in = NW'(scan_idx) + NW'(1);
            end
         end

         // Return to the parent frame and fetch its row again.
         lod_pkg::S_POP: begin
            cur_v_in   = ss_node;
            cur_n_in   = ss_next;
            mx_rd      = 1'b1;
            mx_rd_addr = ss_node;
            state_in   = lod_pkg::S_SCAN;
         end

         lod_pkg::S_FIN: begin
            if (load_rsp) begin
               state_in = lod_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = lod_pkg::S_IDLE;
         end
      endcase
   end

   // Response valid: set on load, cleared once the word is taken.
   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lod_pkg::S_IDLE;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      thr_ff        <= thr_in;
      lock_ff       <= lock_in;
      top_ff        <= top_in;
      seen_ff       <= seen_in;
      done_ff       <= done_in;
      cur_v_ff      <= cur_v_in;
      cur_n_ff      <= cur_n_in;
      sp_ff         <= sp_in;
      res_status_ff <= res_status_in;
      res_edge_ff   <= res_edge_in;
      res_from_ff   <= res_from_in;
      res_to_ff     <= res_to_in;
   end

   // Output word register.
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_edge_ff   <= res_edge_ff;
         rsp_from_ff   <= lod_pkg::LOCK_W'(res_from_ff);
         rsp_to_ff     <= lod_pkg::LOCK_W'(res_to_ff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_new_edge   = rsp_edge_ff;
   assign rsp_cycle_from = rsp_from_ff;
   assign rsp_cycle_to   = rsp_to_ff;

endmodule

/* src/lod_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lock-order deadlock detector checker
// Port-level properties of the response word, attached to the top level.
// ----------------------------------------------------------------------------
module lod_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [lod_pkg::STATUS_W-1:0]  rsp_status,
   input logic                          rsp_new_edge,
   input logic [lod_pkg::LOCK_W-1:0]    rsp_cycle_from,
   input logic [lod_pkg::LOCK_W-1:0]    rsp_cycle_to
);

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_cycle_from) && $stable(rsp_cycle_to))
      else $error("stalled response word changed");

   // A deadlock is only found right after a new order edge.
   a_dl_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == lod_pkg::STAT_DEADLOCK) |-> rsp_new_edge)
      else $error("deadlock reported without a new edge");

   // The back edge is reported only with a deadlock.
   a_cycle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != lod_pkg::STAT_DEADLOCK) |->
      (rsp_cycle_from == '0) && (rsp_cycle_to == '0))
      else $error("back edge reported without a deadlock");

   // Halted, overflow and release words never carry a new edge.
   a_no_edge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == lod_pkg::STAT_HALTED) ||
      (rsp_status == lod_pkg::STAT_OVERFLOW) ||
      (rsp_status == lod_pkg::STAT_REL_EMPTY) ||
      (rsp_status == lod_pkg::STAT_REL_MISMATCH)) |-> !rsp_new_edge)
      else $error("new edge flagged on a word that adds none");

   // Once a request word is taken, the request side stalls on the next cycle.
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      $past(req_valid && !req_stall) && !$past(reset) |-> req_stall)
      else $error("request taken again before the previous one finished");

endmodule

bind lock_order_deadlock_detector lod_checker u_lod_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_new_edge   (rsp_new_edge),
   .rsp_cycle_from (rsp_cycle_from),
   .rsp_cycle_to   (rsp_cycle_to)
);
